[src/bwts_pkg.sv]
`default_nettype none
package bwts_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 12;
	localparam int SIZE_BITS  = 7;
	localparam int IN_BITS    = 16;
	localparam int OUT_BITS   = 16;
	localparam int POS_BITS   = 6;
	localparam int FRAC_ONE   = 1 << FRAC_BITS;
	localparam int HALF       = 1 << (FRAC_BITS - 1);
	localparam int ROUND_BIAS = 1 << (2 * FRAC_BITS - 1);

	typedef enum logic [1:0] {
		OP_WRITE    = 2'd0,
		OP_NEAREST  = 2'd1,
		OP_BILINEAR = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

endpackage
`default_nettype wire

[src/bwts_axis.sv]
`default_nettype none
module bwts_axis #(
	parameter int MAX_SIZE = 64
) (
	input  wire logic                               clk,
	input  wire logic                               en_s1,
	input  wire logic                               en_s2,
	input  wire logic                               nearest,
	input  wire logic [bwts_pkg::COORD_BITS-1:0]    coord,
	input  wire logic [bwts_pkg::SIZE_BITS-1:0]     size,
	output logic      [$clog2(MAX_SIZE)-1:0]        idx0_s2,
	output logic      [$clog2(MAX_SIZE)-1:0]        idx1_s2,
	output logic      [bwts_pkg::FRAC_BITS-1:0]     frac_s2
);
	import bwts_pkg::*;

	localparam int IW = $clog2(MAX_SIZE);
	localparam int PW = COORD_BITS + SIZE_BITS + 1;
	localparam int QW = COORD_BITS - FRAC_BITS + SIZE_BITS + 1;
	localparam int BW = PW - FRAC_BITS + 1;

	logic signed [PW-1:0]    prod_s1;
	logic signed [QW-1:0]    qw_s1;
	logic                    near_s1;
	logic signed [PW:0]      rnd_sum;
	logic signed [BW-1:0]    sel;
	logic signed [BW-1:0]    diff;
	logic        [SIZE_BITS:0] d;
	logic        [SIZE_BITS:0] i0w;
	logic        [SIZE_BITS:0] i1w;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_s1 <= $signed(coord) * $signed({1'b0, size});
			qw_s1   <= $signed(coord[COORD_BITS-1:FRAC_BITS]) * $signed({1'b0, size});
			near_s1 <= nearest;
		end
	end

	// scaled position minus floor(coord) * size lands in 0..size
	always_comb begin
		rnd_sum = {prod_s1[PW-1], prod_s1}
			+ (prod_s1[PW-1] ? (PW+1)'(HALF - 1) : (PW+1)'(HALF));
		sel  = near_s1 ? rnd_sum[PW:FRAC_BITS] : {prod_s1[PW-1], prod_s1[PW-1:FRAC_BITS]};
		diff = sel - BW'(qw_s1);
		d    = diff[SIZE_BITS:0];
		i0w  = (d == {1'b0, size}) ? '0 : d;
		i1w  = ((i0w + 1'b1) == {1'b0, size}) ? '0 : i0w + 1'b1;
	end

	// nearest reads the same texel on every port
	always_ff @(posedge clk) begin
		if (en_s2) begin
			idx0_s2 <= IW'(i0w);
			idx1_s2 <= near_s1 ? IW'(i0w) : IW'(i1w);
			frac_s2 <= near_s1 ? '0 : prod_s1[FRAC_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

[src/bwts_store.sv]
`default_nettype none
module bwts_store #(
	parameter int MAX_WIDTH    = 64,
	parameter int MAX_HEIGHT   = 64,
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            wr_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]    wr_x,
	input  wire logic [$clog2(MAX_HEIGHT)-1:0]   wr_y,
	input  wire logic [4*CHANNEL_BITS-1:0]       wr_data,
	input  wire logic                            rd_en,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]    x0,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]    x1,
	input  wire logic [$clog2(MAX_HEIGHT)-1:0]   y0,
	input  wire logic [$clog2(MAX_HEIGHT)-1:0]   y1,
	output logic      [4*CHANNEL_BITS-1:0]       p00_s3,
	output logic      [4*CHANNEL_BITS-1:0]       p01_s3,
	output logic      [4*CHANNEL_BITS-1:0]       p10_s3,
	output logic      [4*CHANNEL_BITS-1:0]       p11_s3
);
	import bwts_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// two copies, each with two read ports, give four reads a cycle
	logic [4*CHANNEL_BITS-1:0] mem_a [DEPTH];
	logic [4*CHANNEL_BITS-1:0] mem_b [DEPTH];
	logic [AW-1:0] wa, a00, a01, a10, a11;

	assign wa  = AW'(32'(wr_y) * MAX_WIDTH + 32'(wr_x));
	assign a00 = AW'(32'(y0) * MAX_WIDTH + 32'(x0));
	assign a01 = AW'(32'(y1) * MAX_WIDTH + 32'(x0));
	assign a10 = AW'(32'(y0) * MAX_WIDTH + 32'(x1));
	assign a11 = AW'(32'(y1) * MAX_WIDTH + 32'(x1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wa] <= wr_data;
			mem_b[wa] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			p00_s3 <= mem_a[a00];
			p01_s3 <= mem_a[a01];
			p10_s3 <= mem_b[a10];
			p11_s3 <= mem_b[a11];
		end
	end

endmodule
`default_nettype wire

[src/bwts_blend.sv]
`default_nettype none
module bwts_blend #(
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              en_s4,
	input  wire logic                              en_s5,
	input  wire logic [bwts_pkg::FRAC_BITS-1:0]    fx,
	input  wire logic [bwts_pkg::FRAC_BITS-1:0]    fy,
	input  wire logic [4*CHANNEL_BITS-1:0]         p00,
	input  wire logic [4*CHANNEL_BITS-1:0]         p01,
	input  wire logic [4*CHANNEL_BITS-1:0]         p10,
	input  wire logic [4*CHANNEL_BITS-1:0]         p11,
	output logic      [4*bwts_pkg::OUT_BITS-1:0]   res_s5
);
	import bwts_pkg::*;

	localparam int WW = FRAC_BITS + 1;
	localparam int LW = CHANNEL_BITS + FRAC_BITS;
	localparam int CW = CHANNEL_BITS + 2 * FRAC_BITS;
	localparam int CB = CHANNEL_BITS;

	logic [WW-1:0] ny, nx;
	logic [LW-1:0] left_d  [4];
	logic [LW-1:0] right_d [4];
	logic [LW-1:0] left_s4 [4];
	logic [LW-1:0] right_s4[4];
	logic [WW-1:0] nx_s4, ux_s4;
	logic [CW-1:0] acc     [4];

	always_comb begin
		ny = WW'(FRAC_ONE) - WW'(fy);
		nx = WW'(FRAC_ONE) - WW'(fx);
		for (int c = 0; c < 4; c++) begin
			left_d[c]  = LW'(ny) * LW'(p00[c*CB +: CB]) + LW'(fy) * LW'(p01[c*CB +: CB]);
			right_d[c] = LW'(ny) * LW'(p10[c*CB +: CB]) + LW'(fy) * LW'(p11[c*CB +: CB]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int c = 0; c < 4; c++) begin
				left_s4[c]  <= left_d[c];
				right_s4[c] <= right_d[c];
			end
			nx_s4 <= nx;
			ux_s4 <= WW'(fx);
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			acc[c] = CW'(nx_s4) * CW'(left_s4[c]) + CW'(ux_s4) * CW'(right_s4[c])
				+ CW'(ROUND_BIAS);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int c = 0; c < 4; c++) begin
				res_s5[c*OUT_BITS +: OUT_BITS] <= OUT_BITS'(acc[c] >> (2 * FRAC_BITS));
			end
		end
	end

endmodule
`default_nettype wire

[src/bilinear_wrap_texture_sampler.sv]
// Texture sampler with repeat addressing over a stored four-channel image.
// Input channel (in_valid/in_ready): op selects a texel write, a nearest
// sample or a bilinear sample; op 3 is taken and dropped. Writes give no result.
// Output channel (out_valid/out_ready): one result per sample, in order.
// Config channel (cfg_valid/cfg_ready): index 0 image width, 1 image height;
// always ready, write only while the sampler is idle.
// Throughput: one item per cycle unless a stall on out_ready holds the pipeline.
// A sample's result shows on out_valid after five pipeline stages:
// coordinate scale, wrap and address, store read, row blend, column blend.
// The store has two copies with two read ports each, which sets the
// four-reads-per-cycle rate.
// Reset clears all stage valid bits and sets both sizes to 64; stored texels
// are undefined until written. When the receiver stalls, the output stage
// holds and stages behind it fill their bubbles before in_ready drops.
`default_nettype none
module bilinear_wrap_texture_sampler #(
	parameter int MAX_WIDTH    = 64,
	parameter int MAX_HEIGHT   = 64,
	parameter int CHANNEL_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic                              cfg_index,
	input  wire logic [bwts_pkg::SIZE_BITS-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        op,
	input  wire logic [bwts_pkg::POS_BITS-1:0]     texel_x,
	input  wire logic [bwts_pkg::POS_BITS-1:0]     texel_y,
	input  wire logic [bwts_pkg::IN_BITS-1:0]      red_in,
	input  wire logic [bwts_pkg::IN_BITS-1:0]      green_in,
	input  wire logic [bwts_pkg::IN_BITS-1:0]      blue_in,
	input  wire logic [bwts_pkg::IN_BITS-1:0]      alpha_in,
	input  wire logic [bwts_pkg::COORD_BITS-1:0]   coord_u,
	input  wire logic [bwts_pkg::COORD_BITS-1:0]   coord_v,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [bwts_pkg::OUT_BITS-1:0]     red_out,
	output logic      [bwts_pkg::OUT_BITS-1:0]     green_out,
	output logic      [bwts_pkg::OUT_BITS-1:0]     blue_out,
	output logic      [bwts_pkg::OUT_BITS-1:0]     alpha_out
);
	import bwts_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int CB = CHANNEL_BITS;

	logic [SIZE_BITS-1:0] width_q, height_q;
	logic [SIZE_BITS-1:0] size_w, size_h;

	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic wr_s1, wr_s2;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic wok_s1, wok_s2;
	logic [XW-1:0] wx_s1, wx_s2;
	logic [YW-1:0] wy_s1, wy_s2;
	logic [4*CB-1:0] wd_s1, wd_s2;
	logic [4*CB-1:0] p00_s3, p01_s3, p10_s3, p11_s3;
	logic [XW-1:0] x0_s2, x1_s2;
	logic [YW-1:0] y0_s2, y1_s2;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2, fx_s3, fy_s3;
	logic [4*OUT_BITS-1:0] res_s5;
	logic in_take, in_live, nearest;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_BITS'(64);
			height_q <= SIZE_BITS'(64);
		end else if (cfg_valid) begin
			if (cfg_index == REG_WIDTH) width_q <= cfg_data;
			if (cfg_index == REG_HEIGHT) height_q <= cfg_data;
		end
	end

	always_comb begin
		if (width_q == '0) size_w = SIZE_BITS'(1);
		else if (32'(width_q) > MAX_WIDTH) size_w = SIZE_BITS'(MAX_WIDTH);
		else size_w = width_q;
		if (height_q == '0) size_h = SIZE_BITS'(1);
		else if (32'(height_q) > MAX_HEIGHT) size_h = SIZE_BITS'(MAX_HEIGHT);
		else size_h = height_q;
	end

	// write items leave at stage two and never block it
	assign rdy5     = !v5_s5 || out_ready;
	assign rdy4     = !v4_s4 || rdy5;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || wr_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_ready = rdy1;
	assign in_take  = in_valid && in_ready;
	assign in_live  = op_t'(op) != OP_NONE;
	assign nearest  = op_t'(op) == OP_NEAREST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_take && in_live;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2 && !wr_s2;
			if (rdy4) v4_s4 <= v3_s3;
			if (rdy5) v5_s5 <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			wr_s1  <= op_t'(op) == OP_WRITE;
			wok_s1 <= (32'(texel_x) < MAX_WIDTH) && (32'(texel_y) < MAX_HEIGHT);
			wx_s1  <= XW'(texel_x);
			wy_s1  <= YW'(texel_y);
			wd_s1  <= {CB'(alpha_in), CB'(blue_in), CB'(green_in), CB'(red_in)};
		end
		if (rdy2) begin
			wr_s2  <= wr_s1;
			wok_s2 <= wok_s1;
			wx_s2  <= wx_s1;
			wy_s2  <= wy_s1;
			wd_s2  <= wd_s1;
		end
		if (rdy3) begin
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
		end
	end

	bwts_axis #(.MAX_SIZE(MAX_WIDTH)) u_axis_x (
		.clk     (clk),
		.en_s1   (rdy1),
		.en_s2   (rdy2),
		.nearest (nearest),
		.coord   (coord_u),
		.size    (size_w),
		.idx0_s2 (x0_s2),
		.idx1_s2 (x1_s2),
		.frac_s2 (fx_s2)
	);

	bwts_axis #(.MAX_SIZE(MAX_HEIGHT)) u_axis_y (
		.clk     (clk),
		.en_s1   (rdy1),
		.en_s2   (rdy2),
		.nearest (nearest),
		.coord   (coord_v),
		.size    (size_h),
		.idx0_s2 (y0_s2),
		.idx1_s2 (y1_s2),
		.frac_s2 (fy_s2)
	);

	bwts_store #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (v2_s2 && wr_s2 && wok_s2),
		.wr_x    (wx_s2),
		.wr_y    (wy_s2),
		.wr_data (wd_s2),
		.rd_en   (rdy3),
		.x0      (x0_s2),
		.x1      (x1_s2),
		.y0      (y0_s2),
		.y1      (y1_s2),
		.p00_s3  (p00_s3),
		.p01_s3  (p01_s3),
		.p10_s3  (p10_s3),
		.p11_s3  (p11_s3)
	);

	bwts_blend #(.CHANNEL_BITS(CHANNEL_BITS)) u_blend (
		.clk    (clk),
		.en_s4  (rdy4),
		.en_s5  (rdy5),
		.fx     (fx_s3),
		.fy     (fy_s3),
		.p00    (p00_s3),
		.p01    (p01_s3),
		.p10    (p10_s3),
		.p11    (p11_s3),
		.res_s5 (res_s5)
	);

	assign out_valid = v5_s5;
	assign red_out   = res_s5[0*OUT_BITS +: OUT_BITS];
	assign green_out = res_s5[1*OUT_BITS +: OUT_BITS];
	assign blue_out  = res_s5[2*OUT_BITS +: OUT_BITS];
	assign alpha_out = res_s5[3*OUT_BITS +: OUT_BITS];

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_s2 && wr_s2 && rdy3) |=> !v3_s3)
		else $error("write transfer reached the read stage");

	a_op_none_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && op_t'(op) == OP_NONE) |=> !v1_s1)
		else $error("unused opcode entered the pipeline");

	a_wrap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_s2 && !wr_s2) |-> (32'(x0_s2) < 32'(size_w) && 32'(y1_s2) < 32'(size_h)))
		else $error("wrapped texel index out of range");

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
	import bwts_pkg::*;

	localparam int STORE_W = 64;
	localparam int STORE_H = 64;
	localparam int LATENCY_WAIT = 12;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [OUT_BITS-1:0] red;
		logic [OUT_BITS-1:0] green;
		logic [OUT_BITS-1:0] blue;
		logic [OUT_BITS-1:0] alpha;
	} texel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_WIDTH;
	logic [SIZE_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	op_t op = OP_WRITE;
	logic [POS_BITS-1:0] texel_x = '0;
	logic [POS_BITS-1:0] texel_y = '0;
	logic [IN_BITS-1:0] red_in = '0;
	logic [IN_BITS-1:0] green_in = '0;
	logic [IN_BITS-1:0] blue_in = '0;
	logic [IN_BITS-1:0] alpha_in = '0;
	logic [COORD_BITS-1:0] coord_u = '0;
	logic [COORD_BITS-1:0] coord_v = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [OUT_BITS-1:0] red_out;
	logic [OUT_BITS-1:0] green_out;
	logic [OUT_BITS-1:0] blue_out;
	logic [OUT_BITS-1:0] alpha_out;

	texel_t texels[STORE_W*STORE_H];
	bit written[STORE_W*STORE_H];
	logic [SIZE_BITS-1:0] width_reg = 7'd64;
	logic [SIZE_BITS-1:0] height_reg = 7'd64;
	texel_t pending_samples[$];

	int errors = 0;
	int n_samples = 0;
	int n_writes = 0;
	int n_settings = 0;
	int burst_left = 0;
	int stall_cycles = 0;
	bit hold_req = 1'b0;

	bilinear_wrap_texture_sampler i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.texel_x(texel_x), .texel_y(texel_y),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
		.coord_u(coord_u), .coord_v(coord_v),
		.out_valid(out_valid), .out_ready(out_ready),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.alpha_out(alpha_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endfunction

	function automatic longint clamp_size(logic [SIZE_BITS-1:0] r, longint maxv);
		longint s;
		s = r;
		if (s < 1) s = 1;
		if (s > maxv) s = maxv;
		return s;
	endfunction

	function automatic longint wrap_pos(longint i, longint n);
		longint r;
		r = i % n;
		return (r < 0) ? r + n : r;
	endfunction

	function automatic longint round_away(longint p);
		if (p >= 0) return (p + HALF) / FRAC_ONE;
		return -((-p + HALF) / FRAC_ONE);
	endfunction

	// neighbour order: 00, 01, 10, 11 (x then y)
	function automatic void locate(input op_t o, input logic [COORD_BITS-1:0] u,
			input logic [COORD_BITS-1:0] v, output int xs[4], output int ys[4],
			output longint fx, output longint fy);
		longint su, sv, pu, pv, w, h, bx, by;
		su = $signed(u);
		sv = $signed(v);
		w = clamp_size(width_reg, STORE_W);
		h = clamp_size(height_reg, STORE_H);
		pu = su * w;
		pv = sv * h;
		if (o == OP_NEAREST) begin
			for (int k = 0; k < 4; k++) begin
				xs[k] = int'(wrap_pos(round_away(pu), w));
				ys[k] = int'(wrap_pos(round_away(pv), h));
			end
			fx = 0;
			fy = 0;
		end else begin
			fx = wrap_pos(pu, FRAC_ONE);
			fy = wrap_pos(pv, FRAC_ONE);
			bx = (pu - fx) / FRAC_ONE;
			by = (pv - fy) / FRAC_ONE;
			xs[0] = int'(wrap_pos(bx, w));
			xs[1] = xs[0];
			xs[2] = int'(wrap_pos(bx + 1, w));
			xs[3] = xs[2];
			ys[0] = int'(wrap_pos(by, h));
			ys[2] = ys[0];
			ys[1] = int'(wrap_pos(by + 1, h));
			ys[3] = ys[1];
		end
	endfunction

	function automatic longint blend(longint fx, longint fy, longint p00, longint p01,
			longint p10, longint p11);
		longint left, right, acc;
		left = (FRAC_ONE - fy) * p00 + fy * p01;
		right = (FRAC_ONE - fy) * p10 + fy * p11;
		acc = (FRAC_ONE - fx) * left + fx * right + ROUND_BIAS;
		return (acc >> (2 * FRAC_BITS)) & 16'hFFFF;
	endfunction

	function automatic texel_t filter_texel(op_t o, logic [COORD_BITS-1:0] u,
			logic [COORD_BITS-1:0] v);
		int xs[4];
		int ys[4];
		longint fx, fy;
		texel_t t[4];
		texel_t res;
		locate(o, u, v, xs, ys, fx, fy);
		for (int k = 0; k < 4; k++) t[k] = texels[ys[k]*STORE_W + xs[k]];
		if (o == OP_NEAREST) return t[0];
		res.red = OUT_BITS'(blend(fx, fy, t[0].red, t[1].red, t[2].red, t[3].red));
		res.green = OUT_BITS'(blend(fx, fy, t[0].green, t[1].green, t[2].green, t[3].green));
		res.blue = OUT_BITS'(blend(fx, fy, t[0].blue, t[1].blue, t[2].blue, t[3].blue));
		res.alpha = OUT_BITS'(blend(fx, fy, t[0].alpha, t[1].alpha, t[2].alpha, t[3].alpha));
		return res;
	endfunction

	task automatic send_item(op_t o, int x, int y, texel_t c, logic [COORD_BITS-1:0] u,
			logic [COORD_BITS-1:0] v);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= o;
		texel_x <= POS_BITS'(x);
		texel_y <= POS_BITS'(y);
		red_in <= c.red;
		green_in <= c.green;
		blue_in <= c.blue;
		alpha_in <= c.alpha;
		coord_u <= u;
		coord_v <= v;
		do @(posedge clk); while (!in_ready);
		case (o)
			OP_WRITE: begin
				texels[y*STORE_W + x] = c;
				written[y*STORE_W + x] = 1'b1;
				n_writes++;
			end
			OP_NEAREST, OP_BILINEAR: begin
				pending_samples.push_back(filter_texel(o, u, v));
				n_samples++;
			end
			default: ;
		endcase
	endtask

	function automatic texel_t rand_texel();
		texel_t t;
		t = {$urandom, $urandom};
		return t;
	endfunction

	task automatic write_texel(int x, int y, texel_t c);
		send_item(OP_WRITE, x, y, c, COORD_BITS'($urandom), COORD_BITS'($urandom));
	endtask

	// fill any neighbour not yet written, then transfer the sample
	task automatic sample(op_t o, logic [COORD_BITS-1:0] u, logic [COORD_BITS-1:0] v);
		int xs[4];
		int ys[4];
		longint fx, fy;
		locate(o, u, v, xs, ys, fx, fy);
		for (int k = 0; k < 4; k++)
			if (!written[ys[k]*STORE_W + xs[k]]) write_texel(xs[k], ys[k], rand_texel());
		send_item(o, $urandom, $urandom, rand_texel(), u, v);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [SIZE_BITS-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_WIDTH) width_reg = value;
		else height_reg = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_size(logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		n_settings++;
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) sample(OP_NEAREST, COORD_BITS'($urandom), COORD_BITS'($urandom));
		else if (r < 85) sample(OP_BILINEAR, COORD_BITS'($urandom), COORD_BITS'($urandom));
		else if (r < 95) write_texel($urandom_range(0, STORE_W-1),
			$urandom_range(0, STORE_H-1), rand_texel());
		else send_item(OP_NONE, $urandom, $urandom, rand_texel(), COORD_BITS'($urandom),
			COORD_BITS'($urandom));
	endtask

	task automatic test_directed();
		write_texel(0, 0, {4{16'hFFFF}});
		write_texel(63, 63, {4{16'h0000}});
		write_texel(63, 0, {4{16'h8000}});
		write_texel(0, 63, {16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF});
		sample(OP_NEAREST, 16'h0000, 16'h0000);
		sample(OP_BILINEAR, 16'h0000, 16'h0000);
		sample(OP_NEAREST, 16'h8000, 16'h8000);
		sample(OP_BILINEAR, 16'h8000, 16'h7FFF);
		sample(OP_BILINEAR, 16'h7FFF, 16'h8000);
		sample(OP_BILINEAR, 16'hFFFF, 16'h0001);
		send_item(OP_NONE, 63, 63, {4{16'hFFFF}}, 16'hFFFF, 16'hFFFF);
		set_size(7'd1, 7'd1);
		sample(OP_NEAREST, 16'd2048, 16'd2047);
		sample(OP_NEAREST, -16'sd2048, -16'sd2049);
		sample(OP_BILINEAR, 16'd2048, -16'sd2048);
		set_size(7'd0, 7'd127);
		sample(OP_NEAREST, 16'h7FFF, 16'h7FFF);
		sample(OP_BILINEAR, 16'h7FFF, 16'h8000);
		set_size(7'd100, 7'd64);
		sample(OP_NEAREST, 16'h8000, 16'h0800);
		sample(OP_BILINEAR, 16'h0FFF, 16'h0FFF);
	endtask

	task automatic test_random_sizes();
		int sizes[8][2] = '{'{1, 1}, '{64, 64}, '{2, 3}, '{64, 1}, '{1, 64}, '{5, 7},
			'{0, 0}, '{127, 2}};
		for (int s = 0; s < 8; s++) begin
			set_size(SIZE_BITS'(sizes[s][0]), SIZE_BITS'(sizes[s][1]));
			repeat (70) random_item();
		end
		for (int s = 0; s < 2; s++) begin
			set_size(SIZE_BITS'($urandom_range(0, 127)), SIZE_BITS'($urandom_range(0, 12)));
			repeat (70) random_item();
		end
	endtask

	task automatic test_backpressure();
		set_size(7'd4, 7'd4);
		hold_req = 1'b1;
		burst_left = 200;
		repeat (120) random_item();
		drain();
		repeat (40) random_item();
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				report("unexpected result", {red_out, green_out, blue_out, alpha_out}, '0);
			end else begin
				texel_t e;
				e = pending_samples.pop_front();
				if (red_out !== e.red) report("red", 64'(red_out), 64'(e.red));
				if (green_out !== e.green) report("green", 64'(green_out), 64'(e.green));
				if (blue_out !== e.blue) report("blue", 64'(blue_out), 64'(e.blue));
				if (alpha_out !== e.alpha) report("alpha", 64'(alpha_out), 64'(e.alpha));
			end
		end
	end

	int rx_hold = 0;
	int rx_mode = 0;
	int rx_left = 0;
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			rx_hold = 400;
		end
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(5, 80);
		end
		rx_left--;
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_mode == 0) begin
			out_ready <= 1'b1;
		end else if (rx_mode == 1) begin
			out_ready <= $urandom_range(0, 1);
		end else begin
			out_ready <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random_sizes();
		test_backpressure();
		drain();
		if (pending_samples.size() != 0)
			report("results left over", 64'(pending_samples.size()), '0);
		$display("covered %0d samples, %0d texel writes over %0d size settings",
			n_samples, n_writes, n_settings);
		$display("nearest and bilinear with wrap, size clamping, dropped opcode, long stall");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire

[files.f]
src/bwts_pkg.sv
src/bwts_axis.sv
src/bwts_store.sv
src/bwts_blend.sv
src/bilinear_wrap_texture_sampler.sv
tb/tb.sv
